// ===== sv/dlft_pkg.sv =====
// Shared types and constants for the data line field tokenizer.
package dlft_pkg;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  // Position relative to a quoted field
  typedef enum logic [1:0] {
    QM_OUT = 2'd0,
    QM_IN  = 2'd1,
    QM_ESC = 2'd2
  } qmode_t;

  // Configuration register indexes
  localparam logic CFG_SEPARATOR  = 1'b0;
  localparam logic CFG_PARSE_STRS = 1'b1;

  // Most result items that one input item can cause
  localparam int MAX_RES = 5;
  localparam int RES_W   = $clog2(MAX_RES + 1);

  // Character constants
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  // One result item as held in the output buffer
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       done;
  } res_t;

  // Build a result item; the byte is zero unless it is a field byte
  function automatic res_t mk_res(kind_t kind, logic [7:0] data, logic done);
    res_t r;
    r.kind = kind;
    r.data = (kind == KIND_BYTE) ? data : 8'h00;
    r.done = done;
    return r;
  endfunction

endpackage

// ===== sv/data_line_field_tokenizer_top.sv =====
// Top level of the data line field tokenizer: input register, decode, result buffer.
// The input register holds an accepted item; it is decoded into the result buffer once
//   that buffer is free, and results leave one per cycle while out_stall is low.
// Throughput: one item per cycle while items cause at most one result and out_stall is low;
//   more results hold the input until the last leaves, set by the single result port.
// Reset: synchronous, active low; empties the buffers, clears quote state and pending flag.
module data_line_field_tokenizer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [7:0]           cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_ch,
  input  logic                 in_has_char,
  input  logic                 in_end_of_line,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output dlft_pkg::kind_t      out_kind,
  output logic [7:0]           out_out_byte,
  output logic                 out_line_done,
  output logic                 out_last_of_run
);

  // configuration registers (reset: separator 0 for whitespace, string parsing on)
  logic [7:0] sep_r;
  logic       pstr_r;

  // input register
  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       has_r;
  logic       eol_r;

  // tokenizer state
  dlft_pkg::qmode_t qmode_r, qmode_nxt;
  logic             fpend_r, fpend_nxt;

  // result buffer
  dlft_pkg::res_t             buf_r [dlft_pkg::MAX_RES];
  logic [dlft_pkg::RES_W-1:0] cnt_r, cnt_nxt;
  logic [dlft_pkg::RES_W-1:0] rd_r, rd_nxt;

  // decode results
  dlft_pkg::res_t             res [dlft_pkg::MAX_RES];
  logic [dlft_pkg::RES_W-1:0] n_res;

  logic out_fire, rd_last, buf_free, move;
  logic is_sep;

  // handshake
  assign out_valid       = (cnt_r != '0);
  assign out_fire        = out_valid && !out_stall;
  assign rd_last         = (rd_r == cnt_r - {{(dlft_pkg::RES_W-1){1'b0}}, 1'b1});
  assign buf_free        = !out_valid || (out_fire && rd_last);
  assign move            = in_vld_r && buf_free;
  assign in_stall        = in_vld_r && !buf_free;

  // result port
  assign out_kind        = buf_r[rd_r].kind;
  assign out_out_byte    = buf_r[rd_r].data;
  assign out_line_done   = buf_r[rd_r].done;
  assign out_last_of_run = rd_last;

  // separator match
  always_comb begin
    if (sep_r == 8'h00) begin
      is_sep = (ch_r == dlft_pkg::CH_SPACE) ||
               (ch_r inside {[dlft_pkg::CH_TAB:dlft_pkg::CH_CR]});
    end else begin
      is_sep = (ch_r == sep_r);
    end
  end

  // decode one item into its result list and next state
  always_comb begin
    qmode_nxt = qmode_r;
    fpend_nxt = fpend_r;
    n_res     = '0;
    for (int i = 0; i < dlft_pkg::MAX_RES; i++) begin
      res[i] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, 8'h00, 1'b0);
    end

    // byte part
    if (has_r) begin
      case (qmode_r)
        dlft_pkg::QM_ESC: begin
          if (ch_r == dlft_pkg::CH_T) begin
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_TAB, 1'b0);
          end else if (ch_r == dlft_pkg::CH_N) begin
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_LF, 1'b0);
          end else begin
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_QMARK, 1'b0);
          end
          n_res     = n_res + 1'b1;
          qmode_nxt = dlft_pkg::QM_IN;
        end
        dlft_pkg::QM_IN: begin
          if (ch_r == dlft_pkg::CH_BSLASH) begin
            qmode_nxt = dlft_pkg::QM_ESC;
          end else if (ch_r == dlft_pkg::CH_QUOTE) begin
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_QUOTE, 1'b0);
            n_res      = n_res + 1'b1;
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_CLOSE, 8'h00, 1'b0);
            n_res      = n_res + 1'b1;
            qmode_nxt  = dlft_pkg::QM_OUT;
          end else begin
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, ch_r, 1'b0);
            n_res      = n_res + 1'b1;
          end
        end
        default: begin
          if (pstr_r && ch_r == dlft_pkg::CH_QUOTE) begin
            // quote opens a field: withdraw unquoted bytes already sent
            if (fpend_r) begin
              res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_DISCARD, 8'h00, 1'b0);
              n_res      = n_res + 1'b1;
            end
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_QUOTE, 1'b0);
            n_res      = n_res + 1'b1;
            fpend_nxt  = 1'b0;
            qmode_nxt  = dlft_pkg::QM_IN;
          end else if (is_sep) begin
            if (fpend_r) begin
              res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_CLOSE, 8'h00, 1'b0);
              n_res      = n_res + 1'b1;
            end
            fpend_nxt = 1'b0;
          end else begin
            res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, ch_r, 1'b0);
            n_res      = n_res + 1'b1;
            fpend_nxt  = 1'b1;
          end
        end
      endcase
    end

    // line end part: close an open quoted field, then the final field
    if (eol_r) begin
      if (qmode_nxt != dlft_pkg::QM_OUT) begin
        if (qmode_nxt == dlft_pkg::QM_ESC) begin
          res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_BSLASH, 1'b0);
          n_res      = n_res + 1'b1;
        end
        res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_BYTE, dlft_pkg::CH_QUOTE, 1'b0);
        n_res      = n_res + 1'b1;
        res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_CLOSE, 8'h00, 1'b0);
        n_res      = n_res + 1'b1;
      end
      res[n_res] = dlft_pkg::mk_res(dlft_pkg::KIND_CLOSE, 8'h00, 1'b1);
      n_res      = n_res + 1'b1;
      qmode_nxt  = dlft_pkg::QM_OUT;
      fpend_nxt  = 1'b0;
    end
  end

  // buffer count and read pointer
  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (move) begin
      cnt_nxt = n_res;
      rd_nxt  = '0;
    end else if (out_fire) begin
      if (rd_last) begin
        cnt_nxt = '0;
        rd_nxt  = '0;
      end else begin
        rd_nxt = rd_r + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= 8'h00;
      pstr_r   <= 1'b1;
      in_vld_r <= 1'b0;
      qmode_r  <= dlft_pkg::QM_OUT;
      fpend_r  <= 1'b0;
      cnt_r    <= '0;
      rd_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          dlft_pkg::CFG_SEPARATOR:  sep_r  <= cfg_data;
          dlft_pkg::CFG_PARSE_STRS: pstr_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (move) begin
        qmode_r <= qmode_nxt;
        fpend_r <= fpend_nxt;
      end
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_r  <= in_ch;
      has_r <= in_has_char;
      eol_r <= in_end_of_line;
    end
    if (move) begin
      for (int i = 0; i < dlft_pkg::MAX_RES; i++) begin
        buf_r[i] <= res[i];
      end
    end
  end

endmodule

// ===== sv/dlft_checker.sv =====
// Port-level checker for the data line field tokenizer, bound to the top level.
module dlft_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input dlft_pkg::kind_t out_kind,
  input logic [7:0]      out_out_byte,
  input logic            out_line_done,
  input logic            out_last_of_run
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_out_byte)
      && $stable(out_line_done) && $stable(out_last_of_run))
    else $error("stalled result item changed");

  // only field bytes carry a byte value
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != dlft_pkg::KIND_BYTE |-> out_out_byte == 8'h00)
    else $error("non-byte result carries a byte");

  // the line close is a close and ends its item's run
  a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_kind == dlft_pkg::KIND_CLOSE && out_last_of_run)
    else $error("line close malformed");

  // a discard is always followed by the opening quote of the same item
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == dlft_pkg::KIND_DISCARD |->
      !out_last_of_run ##1 (!out_valid ||
        (out_kind == dlft_pkg::KIND_BYTE && out_out_byte == dlft_pkg::CH_QUOTE)))
    else $error("discard not followed by opening quote");

endmodule

bind data_line_field_tokenizer_top dlft_checker u_dlft_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_out_byte    (out_out_byte),
  .out_line_done   (out_line_done),
  .out_last_of_run (out_last_of_run)
);
